FILE: sv/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared constants and codes for the region sector allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int unsigned MAX_SECTORS_DEF = 4096;
  localparam int unsigned SECTOR_SIZE_DEF = 4096;
  localparam int unsigned SLOTS           = 1024;
  localparam int unsigned SLOT_W          = 10;

  localparam int unsigned LEN_W   = 13;   // config and file_sectors width
  localparam int unsigned START_W = 24;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CNT_W   = 11;   // chunk_count width

  // payload plus header bytes added before dividing by the sector size
  localparam logic [31:0] HDR_BYTES = 32'd5;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 96;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_WRITE = 2'd1,
    OP_QUERY = 2'd2,
    OP_QALT  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LARGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PL_IN_PLACE = 2'd0,
    PL_REUSED   = 2'd1,
    PL_APPENDED = 2'd2,
    PL_RSVD     = 2'd3
  } place_t;

endpackage

FILE: sv/region_sector_allocator.sv
// ----------------------------------------------------------------------------
// region_sector_allocator
// First-fit contiguous sector allocator over a 1024-slot table and a
// per-sector used map.
// ----------------------------------------------------------------------------
// One item at a time. Query and load-free paths read the slot, evaluate it and
// respond; a load also marks each sector it covers. A write adds a divide step,
// a first-fit walk of the used map (single read port, a read and an evaluate
// state per sector visited), and a pass over each sector freed and marked. After
// reset the block clears both tables, clears the used map and walks the table,
// marking each slot's sectors, before s_tready rises; a configuration write
// reruns the map clear and table walk, with the marking of each sector.
// ----------------------------------------------------------------------------
module region_sector_allocator #(
  parameter int unsigned MAX_SECTORS = rsa_pkg::MAX_SECTORS_DEF,
  parameter int unsigned SECTOR_SIZE = rsa_pkg::SECTOR_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: chunk_x, chunk_z, entry_word, payload_bytes, now
  input  logic [rsa_pkg::IN_DATA_W-1:0]     s_tdata,
  // s_tuser: opcode
  input  logic [1:0]                        s_tuser,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // m_tdata: present, sector_start, sector_count, stamp, chunk_count,
  //          file_sectors
  output logic [rsa_pkg::OUT_DATA_W-1:0]    m_tdata,
  // m_tuser: status, placement
  output logic [3:0]                        m_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [rsa_pkg::LEN_W-1:0]         cfg_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);

  localparam int unsigned LW  = $clog2(MAX_SECTORS + 1);
  localparam int unsigned MW  = $clog2(MAX_SECTORS);
  localparam int unsigned SW  = rsa_pkg::SLOT_W;
  localparam logic [31:0] BIG = 32'(255 * SECTOR_SIZE);
  // reciprocal of the sector size, exact for dividends below 2^24
  localparam int unsigned DIV_L = $clog2(SECTOR_SIZE);
  localparam int unsigned DIV_S = 24 + DIV_L;
  localparam logic [24:0] RECIP =
    25'(((64'd1 << DIV_S) + 64'(SECTOR_SIZE) - 64'd1) / 64'(SECTOR_SIZE));

  typedef enum logic [3:0] {
    CLR_TAB, CLR_MAP, RB_RD, RB_EV, RB_NXT, IDLE, RD, EVAL, DIV, DECIDE,
    SCAN_RD, SCAN_EV, FREE, MARK, COMMIT, RESP
  } state_t;

  state_t state, mk_ret;

  logic [31:0] entry_mem [rsa_pkg::SLOTS];
  logic [31:0] stamp_mem [rsa_pkg::SLOTS];
  logic        map_mem   [MAX_SECTORS];

  logic [31:0]   ent_q, stamp_q;
  logic          map_q;
  logic          tab_we, map_we, map_wdata;
  logic [SW-1:0] tab_waddr, tab_raddr;
  logic [31:0]   ent_wdata, stamp_wdata;
  logic [MW-1:0] map_waddr, map_raddr;

  logic [SW-1:0]  tab_cnt, slot;
  logic [MW-1:0]  map_cnt;
  logic [LW-1:0]  file_length, scan_i, rstart;
  logic [10:0]    present_total;
  rsa_pkg::opcode_t op;
  logic [31:0]    word, now_r, rem, cur_entry, cur_stamp, new_entry;
  logic [7:0]     need;
  logic [8:0]     run;
  logic [24:0]    mk_s;
  logic [7:0]     mk_left;
  logic           mk_val, commit_mark, append;
  rsa_pkg::status_t st;
  rsa_pkg::place_t  pl;

  logic        mk_stop, mk_done;
  logic [31:0] cfg_len;
  logic [48:0] quo_prod;
  logic [8:0]  run_n;
  logic [LW-1:0] rstart_n;

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;

  assign mk_stop = (32'(mk_s) >= 32'(file_length)) || (32'(mk_s) >= MAX_SECTORS);
  assign mk_done = (mk_left == 8'd0) || mk_stop;
  assign quo_prod = 49'(rem[23:0]) * 49'(RECIP);
  assign run_n   = map_q ? 9'd0 : run + 9'd1;
  assign rstart_n = (!map_q && run == 9'd0) ? scan_i : rstart;

  always_comb begin
    if (32'(cfg_data) < 32'd2) begin
      cfg_len = 32'd2;
    end else if (32'(cfg_data) > MAX_SECTORS) begin
      cfg_len = MAX_SECTORS;
    end else begin
      cfg_len = 32'(cfg_data);
    end
  end

  always_comb begin
    tab_we      = 1'b0;
    tab_waddr   = slot;
    ent_wdata   = new_entry;
    stamp_wdata = now_r;
    map_we      = 1'b0;
    map_waddr   = mk_s[MW-1:0];
    map_wdata   = mk_val;
    tab_raddr   = (state == RB_RD) ? tab_cnt : slot;
    map_raddr   = scan_i[MW-1:0];
    if (state == CLR_TAB) begin
      tab_we      = 1'b1;
      tab_waddr   = tab_cnt;
      ent_wdata   = '0;
      stamp_wdata = '0;
    end else if (state == COMMIT) begin
      tab_we = 1'b1;
    end
    if (state == CLR_MAP) begin
      map_we    = 1'b1;
      map_waddr = map_cnt;
      map_wdata = (32'(map_cnt) < 32'd2);
    end else if (state == MARK) begin
      map_we = !mk_done && (mk_s >= 25'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      entry_mem[tab_waddr] <= ent_wdata;
      stamp_mem[tab_waddr] <= stamp_wdata;
    end
    ent_q   <= entry_mem[tab_raddr];
    stamp_q <= stamp_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= CLR_TAB;
      tab_cnt       <= '0;
      map_cnt       <= '0;
      file_length   <= LW'(2);
      present_total <= '0;
      m_tvalid      <= 1'b0;
      mk_left       <= '0;
      mk_ret        <= IDLE;
    end else begin
      if (m_tvalid && m_tready && (state != RESP || cfg_valid)) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        // reopen: rebuild the used map from the table
        file_length <= LW'(cfg_len);
        if (state != CLR_TAB) begin
          state   <= CLR_MAP;
          map_cnt <= '0;
        end
      end else begin
        unique case (state)
          CLR_TAB: begin
            tab_cnt <= tab_cnt + 1'b1;
            if (&tab_cnt) begin
              state   <= CLR_MAP;
              map_cnt <= '0;
            end
          end
          CLR_MAP: begin
            map_cnt <= map_cnt + 1'b1;
            if (map_cnt == MW'(MAX_SECTORS - 1)) begin
              state   <= RB_RD;
              tab_cnt <= '0;
            end
          end
          RB_RD: state <= RB_EV;
          RB_EV: begin
            mk_s    <= {1'b0, ent_q[31:8]};
            mk_left <= ent_q[7:0];
            mk_val  <= 1'b1;
            mk_ret  <= RB_NXT;
            state   <= MARK;
          end
          RB_NXT: begin
            tab_cnt <= tab_cnt + 1'b1;
            state   <= (&tab_cnt) ? IDLE : RB_RD;
          end
          IDLE: begin
            if (s_tvalid) begin
              op     <= rsa_pkg::opcode_t'(s_tuser);
              slot   <= {s_tdata[9:5], s_tdata[4:0]};
              word   <= s_tdata[41:10];
              rem    <= 32'(s_tdata[65:42]) + rsa_pkg::HDR_BYTES;
              now_r  <= s_tdata[97:66];
              st     <= rsa_pkg::ST_OK;
              pl     <= rsa_pkg::PL_IN_PLACE;
              append <= 1'b0;
              state  <= RD;
            end
          end
          RD: state <= EVAL;
          EVAL: begin
            cur_entry <= ent_q;
            cur_stamp <= stamp_q;
            unique case (op)
              rsa_pkg::OP_LOAD: begin
                new_entry   <= word;
                commit_mark <= 1'b1;
                state       <= COMMIT;
              end
              rsa_pkg::OP_WRITE: begin
                if (rem >= BIG) begin
                  st    <= rsa_pkg::ST_LARGE;
                  state <= RESP;
                end else begin
                  state <= DIV;
                end
              end
              rsa_pkg::OP_QUERY, rsa_pkg::OP_QALT: state <= RESP;
            endcase
          end
          DIV: begin
            // rem is below 2^24 here, so the reciprocal product is exact
            need  <= 8'(quo_prod >> DIV_S);
            state <= DECIDE;
          end
          DECIDE: begin
            if (cur_entry[31:8] != 24'd0 && cur_entry[7:0] >= need + 8'd1) begin
              new_entry   <= cur_entry;
              commit_mark <= 1'b0;
              state       <= COMMIT;
            end else begin
              scan_i <= '0;
              run    <= '0;
              rstart <= '0;
              state  <= SCAN_RD;
            end
            need <= need + 8'd1;
          end
          SCAN_RD: begin
            if (scan_i >= file_length) begin
              if (32'(file_length) + 32'(need) > MAX_SECTORS) begin
                st    <= rsa_pkg::ST_FULL;
                state <= RESP;
              end else begin
                new_entry <= {24'(file_length), need};
                pl        <= rsa_pkg::PL_APPENDED;
                append    <= 1'b1;
                state     <= FREE;
              end
            end else begin
              state <= SCAN_EV;
            end
          end
          SCAN_EV: begin
            run    <= run_n;
            rstart <= rstart_n;
            if (run_n >= {1'b0, need}) begin
              new_entry <= {24'(rstart_n), need};
              pl        <= rsa_pkg::PL_REUSED;
              state     <= FREE;
            end else begin
              scan_i <= scan_i + 1'b1;
              state  <= SCAN_RD;
            end
          end
          FREE: begin
            mk_s        <= {1'b0, cur_entry[31:8]};
            mk_left     <= cur_entry[7:0];
            mk_val      <= 1'b0;
            mk_ret      <= COMMIT;
            commit_mark <= 1'b1;
            state       <= MARK;
          end
          MARK: begin
            if (mk_done) begin
              state <= mk_ret;
            end else begin
              mk_s    <= mk_s + 25'd1;
              mk_left <= mk_left - 8'd1;
            end
          end
          COMMIT: begin
            if (cur_entry == 32'd0 && new_entry != 32'd0) begin
              present_total <= present_total + 11'd1;
            end else if (cur_entry != 32'd0 && new_entry == 32'd0) begin
              present_total <= present_total - 11'd1;
            end
            if (append) begin
              file_length <= file_length + LW'(need);
            end
            cur_entry <= new_entry;
            cur_stamp <= now_r;
            mk_s      <= {1'b0, new_entry[31:8]};
            mk_left   <= commit_mark ? new_entry[7:0] : 8'd0;
            mk_val    <= 1'b1;
            mk_ret    <= RESP;
            state     <= MARK;
          end
          RESP: begin
            if (!m_tvalid || m_tready) begin
              m_tvalid <= 1'b1;
              m_tuser  <= {pl, st};
              m_tdata  <= {7'd0, rsa_pkg::LEN_W'(file_length), present_total, cur_stamp,
                           cur_entry[7:0], cur_entry[31:8], (cur_entry != 32'd0)};
              state    <= IDLE;
            end
          end
          default: state <= IDLE;
        endcase
      end
    end
  end

endmodule

FILE: sv/rsa_checker.sv
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks for the region sector allocator.
// ----------------------------------------------------------------------------
module rsa_checker (
  input logic        clk,
  input logic        rst,
  input logic [95:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tvalid,
  input logic        m_tready
);

  property p_hold;
    @(posedge clk) disable iff (rst) m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata);
  endproperty
  a_hold: assert property (p_hold) else $error("result beat dropped or changed");

  property p_reject_no_place;
    @(posedge clk) disable iff (rst)
      m_tvalid && (m_tuser[1:0] == 2'd1 || m_tuser[1:0] == 2'd2) |-> m_tuser[3:2] == 2'd0;
  endproperty
  a_reject: assert property (p_reject_no_place) else $error("rejected write has placement");

  property p_absent_empty;
    @(posedge clk) disable iff (rst)
      m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0;
  endproperty
  a_absent: assert property (p_absent_empty) else $error("empty slot reports a run");

  property p_moved_present;
    @(posedge clk) disable iff (rst)
      m_tvalid && m_tuser[3:2] != 2'd0 |-> m_tdata[0] && m_tdata[32:25] != 8'd0;
  endproperty
  a_moved: assert property (p_moved_present) else $error("moved slot without a run");

endmodule

bind region_sector_allocator rsa_checker u_rsa_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
